/* rtl/core/lsw_pkg.sv */
// Shared types and constants for the light-wipe slot renderer.
// Used by every module in rtl/core; no dependencies of its own.
package lsw_pkg;

   localparam int FRAC_BITS      = 12;
   localparam int ALPHA_W        = FRAC_BITS + 1;
   localparam int COORD_W        = 16;
   localparam int LEN_W          = 16;
   localparam int SRC_W          = 3;
   localparam int RATE_W         = 20;
   localparam int ELAPSED_W      = 16;
   localparam int COLOR_W        = 24;
   localparam int DELTA_W        = RATE_W + ELAPSED_W - (24 - FRAC_BITS);
   localparam int DIAG_SHIFT     = 12;
   localparam int DEF_SLOT_COUNT = 16;

   localparam logic [ALPHA_W-1:0] ONE_FX  = ALPHA_W'(1) << FRAC_BITS;
   localparam logic [11:0]        DIAG_K  = 12'd2896;
   localparam logic [LEN_W-1:0]   LEN_MAX = '1;

   localparam logic [SRC_W-1:0] SRC_MIDI0   = 3'd0;
   localparam logic [SRC_W-1:0] SRC_MIDI1   = 3'd1;
   localparam logic [SRC_W-1:0] SRC_MOUSE_Y = 3'd3;

   localparam logic [1:0] REG_RATE  = 2'd0;
   localparam logic [1:0] REG_SHARP = 2'd1;
   localparam logic [1:0] REG_COLOR = 2'd2;

   typedef enum logic [1:0] {
      PH_OFF    = 2'd0,
      PH_GROW   = 2'd1,
      PH_SHRINK = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      MODE_TICK  = 2'd0,
      MODE_START = 2'd1,
      MODE_END   = 2'd2,
      MODE_PIXEL = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TICK_MUL,
      ST_WALK,
      ST_PIX_EVAL,
      ST_PIX_MUL,
      ST_PIX_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      phase_type                 phase;
      logic [SRC_W-1:0]          source;
      logic signed [COORD_W-1:0] origin_x;
      logic signed [COORD_W-1:0] origin_y;
      logic [LEN_W-1:0]          length;
      logic [ALPHA_W-1:0]        alpha;
   } slot_type;

endpackage

/* rtl/core/led_swipe_wipe_renderer.sv */
// Top level of the light-wipe slot renderer: ring of slot cells, shared slot unit,
// ramp divider and register port. Depends on lsw_pkg, lsw_cell and lsw_divider.
//
//  channel  | direction | handshake                 | payload
//  req_     | in        | req_tvalid / req_tready   | tuser mode, tdata event and pixel fields
//  rsp_     | out       | rsp_tvalid / rsp_tready   | tdata alpha, color, handled
//  csr_     | in        | psel, penable, pready     | 32-bit registers at 0x0, 0x4, 0x8
//
// Slots live in a ring of SLOT_COUNT cells; every work cycle the ring turns by one and
// the slot at cell 0 passes through the update unit back into the top cell, so after a
// full turn the slots sit in their original places again.
// A tick passes ST_TICK_MUL and then walks the ring; start or end walks the ring (mouse_y
// goes straight to ST_DONE); a pixel query walks the ring and holds in ST_PIX_MUL and
// ST_PIX_DIV on every slot whose ramp divides, while the one-bit-per-cycle ramp divider runs.
// Reset clears all slots and loads register defaults.
// A new transaction is taken while a result waits on rsp_; a stalled rsp_ holds the
// finished item in ST_DONE until the output register frees.
module led_swipe_wipe_renderer #(
   parameter int SLOT_COUNT = lsw_pkg::DEF_SLOT_COUNT
) (
   input  logic        clock,
   input  logic        reset,
   // req_tuser: mode[1:0]
   // req_tdata: source_id[2:0], strength[15:3], elapsed_millibeats[31:16],
   //            pixel_x[47:32], pixel_y[63:48]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,
   input  logic [63:0] req_tdata,
   // rsp_tdata: alpha_out[12:0], color_out[36:13], handled[37], zero[39:38]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import lsw_pkg::*;

   localparam int IDX_W  = $clog2(SLOT_COUNT);
   localparam int ACC_W  = $clog2(SLOT_COUNT) + ALPHA_W + 1;
   localparam int WIDE_W = DELTA_W + 2;
   localparam int V_W    = COORD_W + 4;
   localparam int PROD_W = COORD_W + 2 + 13;
   localparam logic signed [WIDE_W-1:0] TWO_W = WIDE_W'(2) <<< FRAC_BITS;

   // registers
   logic [RATE_W-1:0]  rate_ff;
   logic [ALPHA_W-1:0] sharp_ff;
   logic [COLOR_W-1:0] color_ff;
   logic [1:0]         reg_idx;
   logic               csr_wr;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[3:2];
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff  <= RATE_W'(33554);
         sharp_ff <= ALPHA_W'(2048);
         color_ff <= '0;
      end else if (csr_wr) begin
         case (reg_idx)
            REG_RATE:  rate_ff  <= csr_pwdata[RATE_W-1:0];
            REG_SHARP: sharp_ff <= csr_pwdata[ALPHA_W-1:0];
            REG_COLOR: color_ff <= csr_pwdata[COLOR_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_RATE:  csr_prdata = 32'(rate_ff);
         REG_SHARP: csr_prdata = 32'(sharp_ff);
         REG_COLOR: csr_prdata = 32'(color_ff);
         default:   csr_prdata = '0;
      endcase
   end

   // control and item registers
   state_type                  state_ff, state_in;
   mode_type                   mode_ff;
   logic [SRC_W-1:0]           src_ff;
   logic [ALPHA_W-1:0]         strength_ff;
   logic signed [COORD_W-1:0]  px_ff, py_ff;
   logic [DELTA_W-1:0]         delta_ff, diag_ff;
   logic                       found_ff, found_in;
   logic [IDX_W-1:0]           idx_ff, idx_in;
   logic [ACC_W-1:0]           acc_ff, acc_in;
   logic [ALPHA_W-1:0]         diff_ff, diff_in;
   logic [ALPHA_W-1:0]         fuzz_ff, fuzz_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [ALPHA_W-1:0]         rsp_alpha_ff;
   logic [COLOR_W-1:0]         rsp_color_ff;
   logic                       rsp_handled_ff;
   logic                       accept, load_rsp, shift_en, div_start, last_slot;
   logic [RATE_W+ELAPSED_W-1:0] travel;
   logic [DELTA_W+12-1:0]      diag_prod;

   // slot ring
   slot_type cell_q [SLOT_COUNT];
   slot_type head, unit_slot;

   genvar k;
   generate
      for (k = 0; k < SLOT_COUNT; k++) begin : g_ring
         if (k == SLOT_COUNT - 1) begin : g_top
            lsw_cell u_cell (.clock, .reset, .shift_en,
                             .slot_in(unit_slot), .slot_out(cell_q[k]));
         end else begin : g_mid
            lsw_cell u_cell (.clock, .reset, .shift_en,
                             .slot_in(cell_q[k+1]), .slot_out(cell_q[k]));
         end
      end
   endgenerate

   assign head      = cell_q[0];
   assign last_slot = (idx_ff == IDX_W'(SLOT_COUNT - 1));
   assign accept    = req_tvalid & req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign travel    = rate_ff * req_tdata[31:16];
   assign diag_prod = delta_ff * DIAG_K;

   // slot update unit for tick, start and end walks
   logic [DELTA_W:0]           grow_len;
   logic signed [WIDE_W-1:0]   ox_w, oy_w, dl_w, dg_w, ox_n, oy_n;
   logic                       take_start, take_end, in_window;
   logic [ALPHA_W-1:0]         start_alpha;

   always_comb begin
      grow_len = {{(DELTA_W+1-LEN_W){1'b0}}, head.length} + {1'b0, delta_ff};
      ox_w = WIDE_W'(head.origin_x);
      oy_w = WIDE_W'(head.origin_y);
      dl_w = {2'b00, delta_ff};
      dg_w = {2'b00, diag_ff};
      ox_n = ox_w;
      oy_n = oy_w;
      if (head.source == SRC_MIDI0) begin
         ox_n = ox_w - dl_w;
      end else if (head.source == SRC_MIDI1) begin
         ox_n = ox_w + dl_w;
      end else begin
         ox_n = ox_w + dg_w;
         oy_n = oy_w + dg_w;
      end
      in_window = (ox_n > -TWO_W) && (ox_n < TWO_W) && (oy_n > -TWO_W) && (oy_n < TWO_W);
      start_alpha = (strength_ff > ONE_FX) ? ONE_FX : strength_ff;
      take_start = !found_ff && ((head.phase == PH_OFF) || last_slot);
      take_end   = !found_ff && (head.phase == PH_GROW) && (head.source == src_ff);

      unit_slot = head;
      case (mode_ff)
         MODE_TICK: begin
            if (head.phase == PH_GROW) begin
               unit_slot.length = (grow_len > (DELTA_W+1)'(LEN_MAX)) ? LEN_MAX
                                                                    : grow_len[LEN_W-1:0];
            end else if (head.phase == PH_SHRINK) begin
               if (in_window) begin
                  unit_slot.origin_x = ox_n[COORD_W-1:0];
                  unit_slot.origin_y = oy_n[COORD_W-1:0];
               end else begin
                  unit_slot = '0;
               end
            end
         end
         MODE_START: begin
            if (take_start) begin
               unit_slot.phase  = PH_GROW;
               unit_slot.source = src_ff;
               unit_slot.length = '0;
               unit_slot.alpha  = start_alpha;
               if (src_ff == SRC_MIDI0) begin
                  unit_slot.origin_x = COORD_W'(ONE_FX);
                  unit_slot.origin_y = '0;
               end else if (src_ff == SRC_MIDI1) begin
                  unit_slot.origin_x = -COORD_W'(ONE_FX);
                  unit_slot.origin_y = '0;
               end else begin
                  unit_slot.origin_x = -COORD_W'(ONE_FX);
                  unit_slot.origin_y = -COORD_W'(ONE_FX);
                  unit_slot.alpha    = ONE_FX;
               end
            end
         end
         MODE_END: begin
            if (take_end) begin
               unit_slot.phase = PH_SHRINK;
            end
         end
         default: ;
      endcase
   end

   // pixel evaluation of the head slot
   logic [ALPHA_W-1:0]        sharp_sat, half_len, fuzz_c;
   logic signed [COORD_W:0]   dx, dy;
   logic signed [COORD_W+1:0] sumd;
   logic signed [PROD_W-1:0]  proj;
   logic signed [V_W-1:0]     v, len_s, fuzz_s, diff_s;
   logic                      pix_full, pix_ramp;

   always_comb begin
      sharp_sat = (sharp_ff > ONE_FX) ? ONE_FX : sharp_ff;
      half_len  = (head.length[LEN_W-1:1] > (LEN_W-1)'(sharp_sat))
                  ? sharp_sat : head.length[ALPHA_W:1];
      fuzz_c    = half_len;
      dx   = (COORD_W+1)'(px_ff) - (COORD_W+1)'(head.origin_x);
      dy   = (COORD_W+1)'(py_ff) - (COORD_W+1)'(head.origin_y);
      sumd = (COORD_W+2)'(dx) + (COORD_W+2)'(dy);
      proj = PROD_W'(sumd) * PROD_W'($signed({1'b0, DIAG_K}));
      if (head.source == SRC_MIDI0) begin
         v = -V_W'(dx);
      end else if (head.source == SRC_MIDI1) begin
         v = V_W'(dx);
      end else begin
         v = V_W'(proj >>> DIAG_SHIFT);
      end
      len_s  = V_W'({1'b0, head.length});
      fuzz_s = V_W'({1'b0, fuzz_c});
      pix_full = 1'b0;
      pix_ramp = 1'b0;
      diff_s   = '0;
      // off slots and pixels beyond the leading edge add nothing
      if (head.phase != PH_OFF && v <= len_s) begin
         if (v > len_s - fuzz_s) begin
            pix_ramp = 1'b1;
            diff_s   = len_s - v;
         end else if (v > 0) begin
            pix_full = 1'b1;
         end else if (v > -fuzz_s) begin
            pix_ramp = 1'b1;
            diff_s   = fuzz_s + v;
         end
      end
   end

   // ramp divider
   logic [2*ALPHA_W-1:0] ramp_num;
   logic                 div_done;
   logic [ALPHA_W-1:0]   div_quo;

   assign ramp_num = head.alpha * diff_ff;

   lsw_divider u_div (
      .clock, .reset,
      .start(div_start), .numer(ramp_num), .denom(fuzz_ff),
      .done(div_done), .quotient(div_quo)
   );

   // sequencer
   always_comb begin
      state_in  = state_ff;
      found_in  = found_ff;
      idx_in    = idx_ff;
      acc_in    = acc_ff;
      diff_in   = diff_ff;
      fuzz_in   = fuzz_ff;
      shift_en  = 1'b0;
      div_start = 1'b0;
      load_rsp  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               found_in = 1'b0;
               idx_in   = '0;
               acc_in   = '0;
               case (mode_type'(req_tuser))
                  MODE_TICK:  state_in = ST_TICK_MUL;
                  MODE_PIXEL: state_in = ST_PIX_EVAL;
                  default:    state_in = (req_tdata[2:0] == SRC_MOUSE_Y) ? ST_DONE : ST_WALK;
               endcase
            end
         end
         ST_TICK_MUL: state_in = ST_WALK;
         ST_WALK: begin
            shift_en = 1'b1;
            if ((mode_ff == MODE_START && take_start) || (mode_ff == MODE_END && take_end)) begin
               found_in = 1'b1;
            end
            idx_in = idx_ff + IDX_W'(1);
            if (last_slot) begin
               idx_in   = '0;
               state_in = ST_DONE;
            end
         end
         ST_PIX_EVAL: begin
            if (pix_ramp) begin
               diff_in  = diff_s[ALPHA_W-1:0];
               fuzz_in  = fuzz_c;
               state_in = ST_PIX_MUL;
            end else begin
               shift_en = 1'b1;
               if (pix_full) begin
                  acc_in = acc_ff + ACC_W'(head.alpha);
               end
               idx_in = idx_ff + IDX_W'(1);
               if (last_slot) begin
                  idx_in   = '0;
                  state_in = ST_DONE;
               end
            end
         end
         ST_PIX_MUL: begin
            div_start = 1'b1;
            state_in  = ST_PIX_DIV;
         end
         ST_PIX_DIV: begin
            if (div_done) begin
               shift_en = 1'b1;
               acc_in   = acc_ff + ACC_W'(div_quo);
               idx_in   = idx_ff + IDX_W'(1);
               state_in = ST_PIX_EVAL;
               if (last_slot) begin
                  idx_in   = '0;
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = load_rsp ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         found_ff     <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         found_ff     <= found_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: hold item fields, latch travel, fold diagonal step
   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      diff_ff <= diff_in;
      fuzz_ff <= fuzz_in;
      if (accept) begin
         mode_ff     <= mode_type'(req_tuser);
         src_ff      <= req_tdata[2:0];
         strength_ff <= req_tdata[15:3];
         px_ff       <= req_tdata[47:32];
         py_ff       <= req_tdata[63:48];
         delta_ff    <= travel[RATE_W+ELAPSED_W-1:24-FRAC_BITS];
      end
      if (state_ff == ST_TICK_MUL) begin
         diag_ff <= diag_prod[DELTA_W+12-1:DIAG_SHIFT];
      end
      if (load_rsp) begin
         rsp_alpha_ff   <= (mode_ff != MODE_PIXEL) ? '0
                           : (acc_ff > ACC_W'(ONE_FX)) ? ONE_FX : acc_ff[ALPHA_W-1:0];
         rsp_color_ff   <= (mode_ff == MODE_PIXEL) ? color_ff : '0;
         rsp_handled_ff <= (mode_ff == MODE_START || mode_ff == MODE_END) && found_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_handled_ff, rsp_color_ff, rsp_alpha_ff};

   // checks
   a_ring_aligned: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (idx_ff == '0))
      else $error("slot ring not realigned at idle");

   a_alpha_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_alpha_ff <= ONE_FX))
      else $error("pixel alpha above 1.0");

   a_handled_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_handled_ff) |-> (rsp_alpha_ff == '0 && rsp_color_ff == '0))
      else $error("event result carries pixel data");

endmodule

/* rtl/core/lsw_cell.sv */
// One wipe slot of the slot ring; shifts toward its lower neighbor on enable.
// Depends on lsw_pkg.
module lsw_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              shift_en,
   input  lsw_pkg::slot_type slot_in,
   output lsw_pkg::slot_type slot_out
);
   import lsw_pkg::*;

   slot_type slot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
      end else if (shift_en) begin
         slot_ff <= slot_in;
      end
   end

   assign slot_out = slot_ff;

endmodule

/* rtl/core/lsw_divider.sv */
// Restoring divider for the edge ramp, one quotient bit per cycle.
// Depends on lsw_pkg; quotient must fit in ALPHA_W bits.
module lsw_divider (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [2*lsw_pkg::ALPHA_W-1:0] numer,
   input  logic [lsw_pkg::ALPHA_W-1:0]   denom,
   output logic                       done,
   output logic [lsw_pkg::ALPHA_W-1:0]   quotient
);
   import lsw_pkg::*;

   localparam int CNT_W = $clog2(ALPHA_W + 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [ALPHA_W:0]     rem_ff, rem_in;
   logic [ALPHA_W-1:0]   work_ff, work_in;
   logic [ALPHA_W-1:0]   den_ff, den_in;
   logic [ALPHA_W:0]     trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      work_in = work_ff;
      den_in  = den_ff;
      trial   = {rem_ff[ALPHA_W-1:0], work_ff[ALPHA_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(ALPHA_W);
         rem_in  = {1'b0, numer[2*ALPHA_W-1:ALPHA_W]};
         work_in = numer[ALPHA_W-1:0];
         den_in  = denom;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in  = trial - {1'b0, den_ff};
            work_in = {work_ff[ALPHA_W-2:0], 1'b1};
         end else begin
            rem_in  = trial;
            work_in = {work_ff[ALPHA_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      work_ff <= work_in;
      den_ff  <= den_in;
   end

   assign done     = done_ff;
   assign quotient = work_ff;

endmodule
